### rtl/drum_step_sequencer_core_macros.svh
// Assertion macros shared by the drum step sequencer checker.
`ifndef DRUM_STEP_SEQUENCER_CORE_MACROS_SVH
`define DRUM_STEP_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dss assertion failed");

// Next-cycle implication that also holds across reset.
`define DSS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dss assertion failed");

`endif

### rtl/dss_pkg.sv
// Package with types, codes and constants of the drum step sequencer.
`timescale 1ns / 1ps
package dss_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Step period is STEP_DIVIDEND / tempo ticks; the quotient needs DIV_BITS bits.
    localparam int           DIV_BITS      = 14;
    localparam int           DIV_CNT_W     = $clog2(DIV_BITS);
    localparam logic [13:0]  STEP_DIVIDEND = 14'd15000;

    localparam logic [9:0]  REPEAT_LEVEL = 10'd900;
    localparam logic [9:0]  MUTE_LEVEL   = 10'd500;

    localparam logic [8:0]  TEMPO_RESET  = 9'd160;
    localparam logic [15:0] TSS_MAX      = 16'hFFFF;
    localparam logic [9:0]  TSTC_MAX     = 10'h3FF;

    localparam logic [4:0]  RST_TEMPO_STEP  = 5'd5;
    localparam logic [8:0]  RST_TEMPO_MAX   = 9'd300;
    localparam logic [8:0]  RST_TEMPO_MIN   = 9'd40;
    localparam logic [9:0]  RST_REPEAT_MS   = 10'd500;
    localparam logic [6:0]  RST_FILL_CHANCE = 7'd70;
    localparam logic [4:0]  RST_FILL_START  = 5'd28;
    localparam logic [3:0]  RST_PULSE_MS    = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMPO_STEP     = 3'd0,
        CFG_TEMPO_MAX      = 3'd1,
        CFG_TEMPO_MIN      = 3'd2,
        CFG_REPEAT_MS      = 3'd3,
        CFG_FILL_CHANCE    = 3'd4,
        CFG_FILL_START     = 3'd5,
        CFG_CLOCK_PULSE_MS = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic [9:0] ladder_sample;
        logic       shift_held;
        logic [6:0] random_percent;
    } t_in_beat;

    typedef struct packed {
        logic       clock_out;
        logic       drum_trigger;
        logic [8:0] tempo;
        logic [4:0] step_position;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic tempo_zero;
    } t_status;

endpackage

### rtl/dss_ctrl.sv
// Controller state machine of the drum step sequencer.
`timescale 1ns / 1ps
module dss_ctrl
    import dss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DIV_BITS - 1);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = !i_status.tempo_zero;
                if (i_status.tempo_zero || r_cnt == DivLast) begin
                    n_state = ST_WAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_WAIT: begin
                // Commit only when the output register is free this cycle.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/dss_dpath.sv
// Datapath of the drum step sequencer: settings, tick state, divider, output register.
`timescale 1ns / 1ps
module dss_dpath
    import dss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_beat              i_in_data,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output t_out_beat             o_out_data
);

    // Settings
    logic [4:0] r_tempo_step;
    logic [8:0] r_tempo_max;
    logic [8:0] r_tempo_min;
    logic [9:0] r_repeat_ms;
    logic [6:0] r_fill_chance;
    logic [4:0] r_fill_start;
    logic [3:0] r_pulse_ms;

    // Tick state
    logic [8:0]  r_tempo, n_tempo;
    logic [15:0] r_tss;
    logic [9:0]  r_tstc, n_tstc;
    logic [4:0]  r_step_count;
    logic [3:0]  r_clk_left;

    // Latched beat
    logic       r_rep, r_mute, r_shift;
    logic [6:0] r_rnd;

    // Divider
    logic [8:0]          r_rem;
    logic [DIV_BITS-1:0] r_quo;

    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo_step  <= RST_TEMPO_STEP;
            r_tempo_max   <= RST_TEMPO_MAX;
            r_tempo_min   <= RST_TEMPO_MIN;
            r_repeat_ms   <= RST_REPEAT_MS;
            r_fill_chance <= RST_FILL_CHANCE;
            r_fill_start  <= RST_FILL_START;
            r_pulse_ms    <= RST_PULSE_MS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMPO_STEP:     r_tempo_step  <= i_cfg_data[4:0];
                CFG_TEMPO_MAX:      r_tempo_max   <= i_cfg_data[8:0];
                CFG_TEMPO_MIN:      r_tempo_min   <= i_cfg_data[8:0];
                CFG_REPEAT_MS:      r_repeat_ms   <= i_cfg_data[9:0];
                CFG_FILL_CHANCE:    r_fill_chance <= i_cfg_data[6:0];
                CFG_FILL_START:     r_fill_start  <= i_cfg_data[4:0];
                CFG_CLOCK_PULSE_MS: r_pulse_ms    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Load: count the tick and apply the tempo buttons.
    logic        in_rep, in_mute, bump;
    logic [15:0] tss_inc;
    logic [9:0]  tstc_inc, up_sum, dn_lim;
    logic [8:0]  up_val, dn_val;

    always_comb begin
        in_rep   = i_in_data.ladder_sample > REPEAT_LEVEL;
        in_mute  = (i_in_data.ladder_sample > MUTE_LEVEL) &&
                   (i_in_data.ladder_sample < REPEAT_LEVEL);
        tss_inc  = (r_tss != TSS_MAX) ? r_tss + 16'd1 : r_tss;
        tstc_inc = (r_tstc != TSTC_MAX) ? r_tstc + 10'd1 : r_tstc;
        bump     = i_in_data.shift_held && (in_rep || in_mute) && (tstc_inc >= r_repeat_ms);
        up_sum   = {1'b0, r_tempo} + {5'b0, r_tempo_step};
        up_val   = (up_sum > {1'b0, r_tempo_max}) ? r_tempo_max : up_sum[8:0];
        dn_lim   = {1'b0, r_tempo_min} + {5'b0, r_tempo_step};
        dn_val   = ({1'b0, r_tempo} < dn_lim) ? r_tempo_min : r_tempo - {4'b0, r_tempo_step};
        n_tempo  = bump ? (in_mute ? up_val : dn_val) : r_tempo;
        if (!i_in_data.shift_held) begin
            n_tstc = tstc_inc;
        end else if (in_rep || in_mute) begin
            n_tstc = bump ? '0 : tstc_inc;
        end else begin
            n_tstc = TSTC_MAX;
        end
    end

    // One restoring division step per cycle.
    logic [9:0] div_trial, div_diff;
    logic       div_ge;

    always_comb begin
        div_trial = {r_rem, r_quo[DIV_BITS-1]};
        div_ge    = div_trial >= {1'b0, r_tempo};
        div_diff  = div_trial - {1'b0, r_tempo};
    end

    // Commit: step check, trigger rule and clock pulse.
    logic       step_fire, is_rep, is_mute, hit, clk_lvl;
    logic [1:0] in_bar;
    logic [3:0] clk_cnt;

    always_comb begin
        step_fire = (r_tempo != '0) && (r_tss >= {2'b0, r_quo});
        in_bar    = r_step_count[1:0];
        is_rep    = r_rep && !r_shift;
        is_mute   = r_mute && !r_shift;
        if (is_rep) begin
            hit = (in_bar == 2'd0) || (in_bar == 2'd2);
        end else begin
            hit = (in_bar == 2'd0) ||
                  ((r_step_count > r_fill_start) && (r_rnd < r_fill_chance));
        end
        clk_cnt = step_fire ? r_pulse_ms : r_clk_left;
        clk_lvl = clk_cnt != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo      <= TEMPO_RESET;
            r_tss        <= TSS_MAX;
            r_tstc       <= TSTC_MAX;
            r_step_count <= '0;
            r_clk_left   <= '0;
        end else if (i_cmd.load) begin
            r_tempo <= n_tempo;
            r_tss   <= tss_inc;
            r_tstc  <= n_tstc;
        end else if (i_cmd.commit) begin
            if (step_fire) begin
                r_tss        <= '0;
                r_step_count <= r_step_count + 5'd1;
            end
            r_clk_left <= clk_lvl ? clk_cnt - 4'd1 : clk_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rep   <= in_rep;
            r_mute  <= in_mute;
            r_shift <= i_in_data.shift_held;
            r_rnd   <= i_in_data.random_percent;
            r_rem   <= '0;
            r_quo   <= STEP_DIVIDEND;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[8:0] : div_trial[8:0];
            r_quo <= {r_quo[DIV_BITS-2:0], div_ge};
        end
        if (i_cmd.commit) begin
            r_out.clock_out     <= clk_lvl;
            r_out.drum_trigger  <= step_fire && hit && !is_mute;
            r_out.tempo         <= r_tempo;
            r_out.step_position <= r_step_count;
        end
    end

    assign o_status.tempo_zero = (r_tempo == '0);
    assign o_out_data          = r_out;

endmodule

### rtl/drum_step_sequencer_core.sv
// Top level of the drum step sequencer: one millisecond tick in, one status beat out.
`timescale 1ns / 1ps
// Usage
// Each input beat on i_in_valid / o_in_stall is one millisecond tick carrying the
// button-ladder sample, the shift flag and a random percent. Every accepted tick
// yields exactly one output beat on o_out_valid / i_out_stall with the clock level,
// the drum trigger, the current tempo and the step position.
// When a tick is accepted, the tick counters and the tempo buttons are applied. The
// step period 15000 / tempo is then found by a restoring divider that retires one
// quotient bit per cycle, and the commit state then commits the step and loads the
// output register. The block takes no new tick until the last one is committed. With
// a tempo of zero the divider is skipped.
// The output register lets the next tick be accepted while a result waits. If the
// receiver stalls, the next result waits in the commit state, and input beats are
// held off until it can be written.
// Reset is synchronous and active low; it restores all settings to their defaults,
// sets the tempo to 160 and arms the first step to fire on the first tick. Settings are
// to be written via i_cfg_we / i_cfg_idx / i_cfg_data only while idle; not enforced.
module drum_step_sequencer_core
    import dss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    // Command and status between the sequencer control and the datapath.
    t_cmd    cmd;
    t_status status;

    dss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the settings, tempo, counters, divider and output register.
    dss_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

### rtl/dss_checker.sv
// Port-level checker for the drum step sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "drum_step_sequencer_core_macros.svh"
module dss_checker
    import dss_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    logic in_take, out_wait, fresh_take;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_wait   = o_out_valid && i_out_stall;
    assign fresh_take = in_take && !o_out_valid;

    // A stalled output beat stays valid and unchanged.
    `DSS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out_data))

    // After a tick is taken, the block stays busy through its divide and commit states.
    `DSS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall ##1 o_in_stall)

    // With no result pending, no output beat is valid in the cycle right after a tick is taken.
    `DSS_ASSERT_IMP(a_no_early_out, i_clk, i_rst_n, $past(fresh_take), !o_out_valid)

    // Reset leaves the block ready with no result pending.
    `DSS_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind drum_step_sequencer_core dss_checker u_dss_checker (.*);
